// File: rtl/core/lpse_pkg.sv
// Shared types, constants and helpers of the LED pixel stream encoder.
// No dependencies; every other file of the block imports this package.
package lpse_pkg;

    localparam int PIXEL_COUNT     = 64;
    localparam int BYTES_PER_PIXEL = 4;

    localparam int IDX_W      = 6;
    localparam int CHAN_W     = 8;
    localparam int WORD_W     = 32;
    localparam int DUTY_W     = 8;
    localparam int LOW_DUTY_W = 7;
    localparam int ADDR_W     = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int RESET_SLOTS = 2;
    localparam int SLOT_W     = $clog2(PIXEL_COUNT + RESET_SLOTS + 1);
    localparam int BITS_PER_SLOT = 8 * BYTES_PER_PIXEL;
    localparam int BIT_CNT_W  = $clog2(BITS_PER_SLOT);

    localparam logic [CHAN_W-1:0]     GREEN_SCALE    = 8'hB0;
    localparam logic [CHAN_W-1:0]     BLUE_SCALE     = 8'hF0;
    localparam logic [LOW_DUTY_W-1:0] LOW_DUTY_RESET = 7'd29;

    localparam logic [1:0] CMD_SET_PIXEL = 2'd0;
    localparam logic [1:0] CMD_START     = 2'd1;
    localparam logic [1:0] CMD_TICK      = 2'd2;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_RESET  = 2'd1,
        KIND_DONE   = 2'd2,
        KIND_CANCEL = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    // Load request from the control logic to the serializer.
    typedef struct packed {
        logic                     load;
        kind_t                    kind;
        logic                     single;
        logic [BITS_PER_SLOT-1:0] bits;
    } ser_load_t;

    function automatic logic [CHAN_W-1:0] scale_byte(input logic [CHAN_W-1:0] v,
                                                     input logic [CHAN_W-1:0] s);
        logic [2*CHAN_W-1:0] prod;
        prod = v * s;
        return prod[2*CHAN_W-1:CHAN_W];
    endfunction

    // Wire order is green, red, blue, white from the top byte down.
    function automatic logic [WORD_W-1:0] pack_pixel(input logic [CHAN_W-1:0] r,
                                                     input logic [CHAN_W-1:0] g,
                                                     input logic [CHAN_W-1:0] b,
                                                     input logic [CHAN_W-1:0] w);
        logic [CHAN_W-1:0] wb;
        wb = (BYTES_PER_PIXEL == 4) ? w : '0;
        return {scale_byte(g, GREEN_SCALE), r, scale_byte(b, BLUE_SCALE), wb};
    endfunction

endpackage

// File: rtl/core/led_pixel_stream_encoder.sv
// Top level of the LED pixel stream encoder: command decode, frame control,
// low_duty register. Instantiates lpse_pixel_mem and lpse_serializer; uses lpse_pkg.

// A command is taken when start is high and busy is low. A set pixel command does
// not raise busy. A slot tick for a pixel slot keeps busy high through the pixel
// store read, then 32 beats at one per cycle from the serializer's shift register
// (24 beats with three bytes per pixel). A reset-slot tick gives 32 beats, and a
// cancel or finished marker gives a single beat. Results are shown on duty,
// code_kind and last for exactly one cycle each, marked by strobe; the receiver
// must take every beat, as the block cannot be stalled. The pixel store reads as
// zero after reset without any clearing pass.
module led_pixel_stream_encoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lpse_pkg::LOW_DUTY_W-1:0]   cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        command,
    input  logic [lpse_pkg::IDX_W-1:0]        pixel_index,
    input  logic [lpse_pkg::CHAN_W-1:0]       red,
    input  logic [lpse_pkg::CHAN_W-1:0]       green,
    input  logic [lpse_pkg::CHAN_W-1:0]       blue,
    input  logic [lpse_pkg::CHAN_W-1:0]       white,
    output logic                              strobe,
    output logic [lpse_pkg::DUTY_W-1:0]       duty,
    output logic [1:0]                        code_kind,
    output logic                              last
);
    import lpse_pkg::*;

    state_t                state_reg, state_next;
    logic                  running_reg, running_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [LOW_DUTY_W-1:0] low_duty_reg;

    logic              accept;
    logic              wr_en;
    logic              rd_en;
    logic [WORD_W-1:0] rd_data;
    ser_load_t         ld;
    kind_t             ser_kind;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign wr_en  = accept && (command == CMD_SET_PIXEL) &&
                    (32'(pixel_index) < PIXEL_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            running_reg  <= 1'b0;
            slot_reg     <= '0;
            low_duty_reg <= LOW_DUTY_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            slot_reg    <= slot_next;
            if (cfg_we)
            begin
                low_duty_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        running_next = running_reg;
        slot_next    = slot_reg;
        rd_en        = 1'b0;
        ld           = '{load: 1'b0, kind: KIND_DATA, single: 1'b0, bits: '0};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_START)
                begin
                    slot_next = '0;
                    if (running_reg)
                    begin
                        running_next = 1'b0;
                        ld.load      = 1'b1;
                        ld.kind      = KIND_CANCEL;
                        ld.single    = 1'b1;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        running_next = 1'b1;
                    end
                end
                else if (accept && command == CMD_TICK && running_reg)
                begin
                    if (32'(slot_reg) < PIXEL_COUNT)
                    begin
                        rd_en      = 1'b1;
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                    else if (32'(slot_reg) < PIXEL_COUNT + RESET_SLOTS)
                    begin
                        ld.load    = 1'b1;
                        ld.kind    = KIND_RESET;
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        ld.load      = 1'b1;
                        ld.kind      = KIND_DONE;
                        ld.single    = 1'b1;
                        running_next = 1'b0;
                        slot_next    = '0;
                        state_next   = ST_EMIT;
                    end
                end
            end
            ST_FETCH:
            begin
                ld.load    = 1'b1;
                ld.kind    = KIND_DATA;
                ld.bits    = rd_data[WORD_W-1 -: BITS_PER_SLOT];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (strobe && last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    lpse_pixel_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(pixel_index)),
        .wr_data (pack_pixel(red, green, blue, white)),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(slot_reg)),
        .rd_data (rd_data)
    );

    lpse_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (ld),
        .low_duty (low_duty_reg),
        .strobe   (strobe),
        .duty     (duty),
        .kind     (ser_kind),
        .last     (last)
    );

    assign code_kind = ser_kind;

    // Beats only appear while a command is being worked off.
    a_strobe_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (state_reg == ST_EMIT))
        else $error("result beat outside emit state");

    // An idle frame always restarts from the first slot.
    a_idle_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (slot_reg == '0))
        else $error("slot counter nonzero while no frame runs");

    // The final beat of a command ends the burst and frees the block.
    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> (!strobe && !busy))
        else $error("burst did not end after last beat");

    // A pixel tick passes through the fetch state, which is followed directly by its data beats.
    a_fetch_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |=> (strobe && code_kind == KIND_DATA))
        else $error("pixel read not followed by data beats");

endmodule

// File: rtl/core/lpse_pixel_mem.sv
// Pixel store: synchronous memory with one write and one registered read port.
// Entries read as zero until written, tracked by per-entry valid flops. Uses lpse_pkg.
module lpse_pixel_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [lpse_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [lpse_pkg::WORD_W-1:0]   wr_data,
    input  logic                          rd_en,
    input  logic [lpse_pkg::ADDR_W-1:0]   rd_addr,
    output logic [lpse_pkg::WORD_W-1:0]   rd_data
);
    import lpse_pkg::*;

    logic [WORD_W-1:0]      mem [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0] valid_reg;
    logic [WORD_W-1:0]      rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: rtl/core/lpse_serializer.sv
// Bit serializer: turns one loaded slot into a run of duty-code beats, MSB first.
// Depends on lpse_pkg for the load struct and result kinds.
module lpse_serializer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lpse_pkg::ser_load_t               ld,
    input  logic [lpse_pkg::LOW_DUTY_W-1:0]   low_duty,
    output logic                              strobe,
    output logic [lpse_pkg::DUTY_W-1:0]       duty,
    output lpse_pkg::kind_t                   kind,
    output logic                              last
);
    import lpse_pkg::*;

    logic                     active_reg, active_next;
    logic [BITS_PER_SLOT-1:0] shift_reg, shift_next;
    logic [BIT_CNT_W-1:0]     cnt_reg, cnt_next;
    kind_t                    kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        kind_reg  <= kind_next;
    end

    always_comb
    begin
        active_next = active_reg;
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        if (ld.load)
        begin
            active_next = 1'b1;
            shift_next  = ld.bits;
            kind_next   = ld.kind;
            cnt_next    = ld.single ? '0 : BIT_CNT_W'(BITS_PER_SLOT - 1);
        end
        else if (active_reg)
        begin
            shift_next = {shift_reg[BITS_PER_SLOT-2:0], 1'b0};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                active_next = 1'b0;
            end
        end
    end

    assign strobe = active_reg;
    assign kind   = kind_reg;
    assign last   = (cnt_reg == '0);

    always_comb
    begin
        if (kind_reg != KIND_DATA)
        begin
            duty = '0;
        end
        else if (shift_reg[BITS_PER_SLOT-1])
        begin
            duty = {low_duty, 1'b0};
        end
        else
        begin
            duty = {1'b0, low_duty};
        end
    end

endmodule
